// ----- rtl/core/shabs_pkg.sv -----
// ----------------------------------------------------------------------------
// shabs_pkg
// Shared types, constants and round functions of the SHA-256 byte stream
// hasher.
// ----------------------------------------------------------------------------
package shabs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} shabs_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} shabs_out_t;

	// Commands from the message controller to the compression core.
	typedef struct packed {
		logic       start;
		logic       restart;
		logic [2:0] dig_addr;
	} shabs_core_ctl_t;

	// Status from the compression core.
	typedef struct packed {
		logic       done;
		logic [3:0] blk_raddr;
	} shabs_core_sts_t;

	localparam int BLK_WORDS   = 16;
	localparam int CHAIN_WORDS = 8;

	localparam logic [7:0] PAD_MARK      = 8'h80;
	localparam logic [5:0] LENGTH_OFFSET = 6'd56;
	localparam logic [5:0] FILL_LAST     = 6'd63;
	localparam logic [3:0] LEN_BYTES     = 4'd8;
	localparam logic [2:0] WORD_LAST     = 3'd7;

	// Compression timeline, one step per cycle.
	localparam logic [6:0] STEP_LOAD_END   = 7'd8;
	localparam logic [6:0] STEP_BLK_RD0    = 7'd7;
	localparam logic [6:0] STEP_SCHED0     = 7'd8;
	localparam logic [6:0] STEP_SCHED_END  = 7'd71;
	localparam logic [6:0] STEP_ROUND0     = 7'd9;
	localparam logic [6:0] STEP_ROUND_END  = 7'd72;
	localparam logic [6:0] STEP_FIN_RD0    = 7'd73;
	localparam logic [6:0] STEP_FIN_RD_END = 7'd80;
	localparam logic [6:0] STEP_FIN_WR0    = 7'd74;
	localparam logic [6:0] STEP_LAST       = 7'd81;

	localparam logic [31:0] INIT_HASH [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 of a byte stream: byte absorption, message padding, block
// compression and digest output.
// ----------------------------------------------------------------------------
// Each input beat carries at most one message byte and may close the message.
// Ready stays high until the 64th byte of a block arrives or a beat closes
// the message. The 64th byte starts a compression that keeps the block busy
// through eight reads of the chaining value memory, 64 rounds on one shared
// round unit (one round per cycle), and eight read-add-write steps back into
// the chaining value memory. A beat with end_of_message set appends the
// padding one byte per cycle (9 to 72 bytes, with one or two more
// compressions), then delivers the eight digest words, most significant
// first, each read, loaded and then held until the consumer takes it. After
// the last digest word is taken the block starts over with the initial hash
// values and a zero length, ready for the next message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
	import shabs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  shabs_in_t  byte_beat,
	output logic       digest_valid,
	input  logic       digest_ready,
	output shabs_out_t digest_beat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_COMP,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_HOLD
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic [23:0] asm_q;
	logic       mark_q;
	logic [3:0] len_idx_q;
	logic       pad_active_q;
	logic [2:0] emit_idx_q;
	logic       out_valid_q;
	shabs_out_t out_q;

	logic            in_acc, out_acc;
	logic            push_en;
	logic [7:0]      push_byte;
	logic            len_push;
	logic            block_full;
	logic [63:0]     bits_nxt;
	logic            blk_we;
	logic [31:0]     blk_wdata, blk_rdata, chain_rd;
	shabs_core_ctl_t core_ctl;
	shabs_core_sts_t core_sts;

	// Message block buffer, 16 big-endian words.
	shabs_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (fill_q[5:2]),
		.wdata (blk_wdata),
		.raddr (core_sts.blk_raddr),
		.rdata (blk_rdata)
	);

	shabs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (core_ctl),
		.blk_rdata (blk_rdata),
		.sts       (core_sts),
		.chain_rd  (chain_rd)
	);

	always_comb begin
		byte_ready   = (state_q == S_IDLE);
		in_acc       = byte_valid && byte_ready;
		digest_valid = out_valid_q;
		digest_beat  = out_q;
		out_acc      = out_valid_q && digest_ready;

		bits_nxt = bits_q + (byte_beat.byte_present ? 64'd8 : 64'd0);

		// The padding walks through the marker byte, zero bytes up to the
		// length field, then the eight length bytes from the top down.
		len_push  = mark_q && ((len_idx_q != 4'd0) || (fill_q == LENGTH_OFFSET));
		push_en   = 1'b0;
		push_byte = 8'h00;
		if (state_q == S_IDLE) begin
			push_en   = in_acc && byte_beat.byte_present;
			push_byte = byte_beat.data_byte;
		end else if (state_q == S_PAD) begin
			push_en = 1'b1;
			if (!mark_q) begin
				push_byte = PAD_MARK;
			end else if (len_push) begin
				push_byte = total_q[63:56];
			end
		end

		// Bytes are packed into a word and written when its fourth byte arrives.
		blk_we     = push_en && (fill_q[1:0] == 2'b11);
		blk_wdata  = {asm_q, push_byte};
		block_full = push_en && (fill_q == FILL_LAST);

		core_ctl.start    = block_full;
		core_ctl.restart  = (state_q == S_EMIT_HOLD) && out_acc && (emit_idx_q == WORD_LAST);
		core_ctl.dig_addr = emit_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			bits_q       <= '0;
			mark_q       <= 1'b0;
			len_idx_q    <= '0;
			pad_active_q <= 1'b0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						bits_q <= bits_nxt;
						if (byte_beat.end_of_message) begin
							mark_q       <= 1'b0;
							len_idx_q    <= '0;
							pad_active_q <= 1'b1;
						end
						if (block_full) begin
							state_q <= S_COMP;
						end else if (byte_beat.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end else if (len_push) begin
						len_idx_q <= len_idx_q + 4'd1;
					end
					if (block_full) begin
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					if (core_sts.done) begin
						if (len_idx_q == LEN_BYTES) begin
							state_q    <= S_EMIT_RD;
							emit_idx_q <= '0;
						end else if (pad_active_q) begin
							state_q <= S_PAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_HOLD;
				end
				S_EMIT_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (emit_idx_q == WORD_LAST) begin
							bits_q       <= '0;
							len_idx_q    <= '0;
							pad_active_q <= 1'b0;
							state_q      <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 3'd1;
							state_q    <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			asm_q <= {asm_q[15:0], push_byte};
		end
		if (in_acc && byte_beat.end_of_message) begin
			total_q <= bits_nxt;
		end else if ((state_q == S_PAD) && len_push) begin
			total_q <= {total_q[55:0], 8'h00};
		end
		if (state_q == S_EMIT_LD) begin
			out_q.digest_word <= chain_rd;
			out_q.word_index  <= emit_idx_q;
			out_q.last_word   <= (emit_idx_q == WORD_LAST);
		end
	end

endmodule

// ----- rtl/core/shabs_ram.sv -----
// ----------------------------------------------------------------------------
// shabs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module shabs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/shabs_core.sv -----
// ----------------------------------------------------------------------------
// shabs_core
// SHA-256 compression: chaining value memory, message schedule window and a
// single round unit used once per cycle.
// ----------------------------------------------------------------------------
module shabs_core
	import shabs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  shabs_core_ctl_t ctl,
	input  logic [31:0]     blk_rdata,
	output shabs_core_sts_t sts,
	output logic [31:0]     chain_rd
);

	typedef enum logic {C_IDLE, C_RUN} cstate_t;

	cstate_t                 state_q;
	logic [6:0]              step_q;
	logic [CHAIN_WORDS-1:0]  valid_q;
	logic                    rdv_q;
	logic [2:0]              rda_q;

	logic [31:0] r_q [CHAIN_WORDS];
	logic [31:0] w_q [BLK_WORDS];
	logic [31:0] kw_s1;

	logic        run;
	logic [6:0]  sched_off, blk_off, fin_rd_off, fin_wr_off;
	logic [5:0]  sched_j;
	logic        in_load, in_sched, in_round, in_fin_wr;
	logic [2:0]  ch_raddr, ch_waddr;
	logic        ch_we;
	logic [31:0] ch_wdata, ch_rdata;
	logic [31:0] wt, t1, t2, choose, major;

	shabs_ram #(.WIDTH(32), .DEPTH(CHAIN_WORDS)) u_chain_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	always_comb begin
		run        = (state_q == C_RUN);
		sched_off  = step_q - STEP_SCHED0;
		blk_off    = step_q - STEP_BLK_RD0;
		fin_rd_off = step_q - STEP_FIN_RD0;
		fin_wr_off = step_q - STEP_FIN_WR0;
		sched_j    = sched_off[5:0];

		in_load   = run && (step_q != 7'd0) && (step_q <= STEP_LOAD_END);
		in_sched  = run && (step_q >= STEP_SCHED0) && (step_q <= STEP_SCHED_END);
		in_round  = run && (step_q >= STEP_ROUND0) && (step_q <= STEP_ROUND_END);
		in_fin_wr = run && (step_q >= STEP_FIN_WR0) && (step_q <= STEP_LAST);

		if (run && (step_q < 7'(CHAIN_WORDS))) begin
			ch_raddr = step_q[2:0];
		end else if (run && (step_q >= STEP_FIN_RD0) && (step_q <= STEP_FIN_RD_END)) begin
			ch_raddr = fin_rd_off[2:0];
		end else begin
			ch_raddr = ctl.dig_addr;
		end

		// Entries never written since the last restart read as the initial hash.
		chain_rd = rdv_q ? ch_rdata : INIT_HASH[rda_q];

		ch_we    = in_fin_wr;
		ch_waddr = fin_wr_off[2:0];
		ch_wdata = chain_rd + r_q[0];

		if (sched_j[5:4] == 2'b00) begin
			wt = blk_rdata;
		end else begin
			wt = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
		end

		choose = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
		major  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
		t1     = r_q[7] + big_sigma1(r_q[4]) + choose + kw_s1;
		t2     = big_sigma0(r_q[0]) + major;

		sts.done      = run && (step_q == STEP_LAST);
		sts.blk_raddr = blk_off[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			valid_q <= '0;
			rdv_q   <= 1'b0;
			rda_q   <= '0;
		end else begin
			rdv_q <= valid_q[ch_raddr];
			rda_q <= ch_raddr;
			if (ctl.restart) begin
				valid_q <= '0;
			end else if (ch_we) begin
				valid_q[ch_waddr] <= 1'b1;
			end
			case (state_q)
				C_IDLE: begin
					step_q <= '0;
					if (ctl.start) begin
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (step_q == STEP_LAST) begin
						state_q <= C_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_load || in_fin_wr) begin
			for (int k = 0; k < CHAIN_WORDS - 1; k++) begin
				r_q[k] <= r_q[k+1];
			end
			r_q[CHAIN_WORDS-1] <= chain_rd;
		end else if (in_round) begin
			r_q[0] <= t1 + t2;
			r_q[1] <= r_q[0];
			r_q[2] <= r_q[1];
			r_q[3] <= r_q[2];
			r_q[4] <= r_q[3] + t1;
			r_q[5] <= r_q[4];
			r_q[6] <= r_q[5];
			r_q[7] <= r_q[6];
		end
		if (in_sched) begin
			for (int k = 0; k < BLK_WORDS - 1; k++) begin
				w_q[k] <= w_q[k+1];
			end
			w_q[BLK_WORDS-1] <= wt;
			kw_s1            <= ROUND_K[sched_j] + wt;
		end
	end

endmodule
